// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW = 16;
  localparam int CW = 18;
  localparam int MW = CW - 1;
  localparam int SW = 2 * MW + 2;
  localparam int RW = SW / 2;
  localparam int NW = MW + FRAC_BITS + 1;
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int LIM_I = (ONE_I < 32767) ? ONE_I : 32767;
  localparam logic signed [CW-1:0] ONE = CW'(ONE_I);
  localparam logic [NW-1:0] LIM = NW'(LIM_I);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PICK,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DOT,
    ST_FIX,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// Converts a 3x3 rotation matrix into a unit quaternion by Shepperd's method.
// Input channel s_*: s_tdata carries the nine Q1.14 entries m00..m22, and
// s_tuser carries align_to_last. Output channel m_*: m_tdata carries
// q_scalar, q_x, q_y, q_z in Q1.14, and m_tuser carries the invalid flag.
// One item is worked on at a time. After acceptance, a valid item goes
// through these steps before it is loaded into the output register: the
// candidate pick, four squares, an 18-step bit-serial square root with a
// start and a hand-off state, four 32-step bit-serial divisions each with
// a start and a hand-off state, a four-step dot product when its sign is
// aligned with the stored quaternion, the sign step and the output step.
// The square root and the divider retire one bit per cycle. An item whose
// largest candidate is not positive goes from the pick step straight to
// the output step, is loaded with zero outputs and the invalid flag set,
// and leaves the stored quaternion alone. The next item is accepted in the
// cycle after the result is loaded, even if the receiver still stalls. A
// stalled receiver holds the block only when a second result is ready.
// Reset clears the stored previous quaternion and empties the output.
module rotation_matrix_to_quaternion_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  input  logic         s_tuser,  // align_to_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // q_scalar, q_x, q_y, q_z
  output logic         m_tuser   // invalid
);

  localparam int DW = rmq_pkg::DW;
  localparam int CW = rmq_pkg::CW;
  localparam int MW = rmq_pkg::MW;
  localparam int FB = rmq_pkg::FRAC_BITS;

  rmq_pkg::state_t state, state_next;

  logic signed [DW-1:0] a [9];
  logic align;
  logic [MW-1:0] vmag [4];
  logic [3:0] vneg;
  logic bad;
  logic [1:0] idx;
  logic [rmq_pkg::SW-1:0] acc;
  logic [rmq_pkg::RW-1:0] norm;
  logic signed [DW-1:0] q [4];
  logic signed [DW-1:0] last_quat [4];
  logic last_valid;
  logic signed [2*DW+1:0] dot;
  logic signed [2*DW-1:0] dprod;
  logic out_load;
  logic use_last;

  logic sq_start, sq_done, dv_start, dv_done;
  logic [rmq_pkg::RW-1:0] root;
  logic [rmq_pkg::NW-1:0] quo;
  logic [rmq_pkg::NW-1:0] num;

  logic signed [CW-1:0] tr, c0, c1, c2, c3, cmax;
  logic signed [CW-1:0] vs [4];
  logic [1:0] k;
  logic [2*MW-1:0] prod;
  logic [DW-1:0] qmag;
  logic flip;

  assign use_last = align && last_valid;

  always_comb begin
    tr = CW'(a[0]) + CW'(a[4]) + CW'(a[8]);
    c0 = rmq_pkg::ONE + tr;
    c1 = rmq_pkg::ONE + CW'(a[0]) - CW'(a[4]) - CW'(a[8]);
    c2 = rmq_pkg::ONE + CW'(a[4]) - CW'(a[0]) - CW'(a[8]);
    c3 = rmq_pkg::ONE + CW'(a[8]) - CW'(a[0]) - CW'(a[4]);
    k = 2'd0;
    cmax = c0;
    if (c1 > cmax) begin
      k = 2'd1;
      cmax = c1;
    end
    if (c2 > cmax) begin
      k = 2'd2;
      cmax = c2;
    end
    if (c3 > cmax) begin
      k = 2'd3;
      cmax = c3;
    end
    unique case (k)
      2'd0: begin
        vs[0] = cmax;
        vs[1] = CW'(a[7]) - CW'(a[5]);
        vs[2] = CW'(a[2]) - CW'(a[6]);
        vs[3] = CW'(a[3]) - CW'(a[1]);
      end
      2'd1: begin
        vs[1] = cmax;
        vs[0] = CW'(a[7]) - CW'(a[5]);
        vs[2] = CW'(a[1]) + CW'(a[3]);
        vs[3] = CW'(a[2]) + CW'(a[6]);
      end
      2'd2: begin
        vs[2] = cmax;
        vs[0] = CW'(a[2]) - CW'(a[6]);
        vs[1] = CW'(a[1]) + CW'(a[3]);
        vs[3] = CW'(a[5]) + CW'(a[7]);
      end
      default: begin
        vs[3] = cmax;
        vs[0] = CW'(a[3]) - CW'(a[1]);
        vs[1] = CW'(a[2]) + CW'(a[6]);
        vs[2] = CW'(a[5]) + CW'(a[7]);
      end
    endcase
  end

  assign prod = vmag[idx] * vmag[idx];
  assign num = (rmq_pkg::NW'(vmag[idx]) << FB) + rmq_pkg::NW'(norm >> 1);
  assign qmag = (quo > rmq_pkg::LIM) ? DW'(rmq_pkg::LIM) : quo[DW-1:0];
  assign flip = use_last ? dot[2*DW+1] : q[0][DW-1];
  assign dprod = q[idx] * last_quat[idx];

  rmq_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .n     (acc),
    .done  (sq_done),
    .root  (root)
  );

  rmq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (num),
    .den   (norm),
    .done  (dv_done),
    .quo   (quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rmq_pkg::ST_IDLE: if (s_tvalid) state_next = rmq_pkg::ST_PICK;
      rmq_pkg::ST_PICK: state_next = (cmax <= 0) ? rmq_pkg::ST_DONE : rmq_pkg::ST_SQ;
      rmq_pkg::ST_SQ: if (idx == 2'd3) state_next = rmq_pkg::ST_ROOT_GO;
      rmq_pkg::ST_ROOT_GO: state_next = rmq_pkg::ST_ROOT_WAIT;
      rmq_pkg::ST_ROOT_WAIT: if (sq_done) state_next = rmq_pkg::ST_DIV_GO;
      rmq_pkg::ST_DIV_GO: state_next = rmq_pkg::ST_DIV_WAIT;
      rmq_pkg::ST_DIV_WAIT: begin
        if (dv_done) begin
          state_next = (idx == 2'd3) ? (use_last ? rmq_pkg::ST_DOT : rmq_pkg::ST_FIX)
                                     : rmq_pkg::ST_DIV_GO;
        end
      end
      rmq_pkg::ST_DOT: if (idx == 2'd3) state_next = rmq_pkg::ST_FIX;
      rmq_pkg::ST_FIX: state_next = rmq_pkg::ST_DONE;
      rmq_pkg::ST_DONE: if (out_load) state_next = rmq_pkg::ST_IDLE;
      default: state_next = rmq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == rmq_pkg::ST_IDLE);
    sq_start = (state == rmq_pkg::ST_ROOT_GO);
    dv_start = (state == rmq_pkg::ST_DIV_GO);
    out_load = (state == rmq_pkg::ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmq_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      last_valid <= 1'b0;
      idx <= '0;
      for (int i = 0; i < 4; i++) begin
        last_quat[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        rmq_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 9; i++) begin
              a[i] <= s_tdata[DW*i +: DW];
            end
            align <= s_tuser;
          end
          idx <= '0;
          acc <= '0;
          dot <= '0;
        end
        rmq_pkg::ST_PICK: begin
          bad <= (cmax <= 0);
          for (int i = 0; i < 4; i++) begin
            vneg[i] <= vs[i][CW-1];
            vmag[i] <= vs[i][CW-1] ? MW'(-vs[i]) : MW'(vs[i]);
            q[i] <= '0;
          end
        end
        rmq_pkg::ST_SQ: begin
          acc <= acc + rmq_pkg::SW'(prod);
          idx <= idx + 1'b1;
        end
        rmq_pkg::ST_ROOT_WAIT: begin
          if (sq_done) begin
            norm <= root;
          end
        end
        rmq_pkg::ST_DIV_WAIT: begin
          if (dv_done) begin
            q[idx] <= vneg[idx] ? -$signed(qmag) : $signed(qmag);
            idx <= idx + 1'b1;
          end
        end
        rmq_pkg::ST_DOT: begin
          dot <= dot + (2*DW+2)'(dprod);
          idx <= idx + 1'b1;
        end
        rmq_pkg::ST_FIX: begin
          if (flip) begin
            for (int i = 0; i < 4; i++) begin
              q[i] <= -q[i];
            end
          end
        end
        rmq_pkg::ST_DONE: begin
          if (out_load && !bad) begin
            last_valid <= 1'b1;
            for (int i = 0; i < 4; i++) begin
              last_quat[i] <= q[i];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {q[3], q[2], q[1], q[0]};
      m_tuser <= bad;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("invalid result carries a nonzero quaternion");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == rmq_pkg::ST_ROOT_WAIT)
    else $error("square root finished outside its wait state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> state == rmq_pkg::ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_store: assert property (@(posedge clk) disable iff (rst)
    $rose(last_valid) |-> $past(state == rmq_pkg::ST_DONE) && !$past(bad))
    else $error("stored quaternion set without a valid result");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[15:0]) <= 16'sd16384
      && $signed(m_tdata[15:0]) >= -16'sd16384)
    else $error("scalar part out of range");

endmodule

// ===== rtl/rmq_sqrt.sv =====
module rmq_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rmq_pkg::SW-1:0]    n,
  output logic                      done,
  output logic [rmq_pkg::RW-1:0]    root
);

  localparam int STEPS = rmq_pkg::SW / 2;
  localparam int CNTW = $clog2(STEPS + 1);
  localparam int REMW = rmq_pkg::RW + 3;

  logic [rmq_pkg::SW-1:0] nsh;
  logic [REMW-1:0] rem;
  logic [CNTW-1:0] cnt;
  logic busy;
  logic [REMW-1:0] remsh;
  logic [REMW-1:0] trial;

  assign remsh = {rem[REMW-3:0], nsh[rmq_pkg::SW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNTW'(STEPS);
        nsh <= n;
        rem <= '0;
        root <= '0;
      end else if (busy) begin
        nsh <= {nsh[rmq_pkg::SW-3:0], 2'b00};
        if (remsh >= trial) begin
          rem <= remsh - trial;
          root <= {root[rmq_pkg::RW-2:0], 1'b1};
        end else begin
          rem <= remsh;
          root <= {root[rmq_pkg::RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rmq_div.sv =====
module rmq_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rmq_pkg::NW-1:0]    num,
  input  logic [rmq_pkg::RW-1:0]    den,
  output logic                      done,
  output logic [rmq_pkg::NW-1:0]    quo
);

  localparam int CNTW = $clog2(rmq_pkg::NW + 1);

  logic [rmq_pkg::NW-1:0] numsh;
  logic [rmq_pkg::RW-1:0] dreg;
  logic [rmq_pkg::RW-1:0] rem;
  logic [rmq_pkg::RW:0] remsh;
  logic [CNTW-1:0] cnt;
  logic busy;

  assign remsh = {rem, numsh[rmq_pkg::NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNTW'(rmq_pkg::NW);
        numsh <= num;
        dreg <= den;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        numsh <= {numsh[rmq_pkg::NW-2:0], 1'b0};
        if (remsh >= {1'b0, dreg}) begin
          rem <= rmq_pkg::RW'(remsh - {1'b0, dreg});
          quo <= {quo[rmq_pkg::NW-2:0], 1'b1};
        end else begin
          rem <= remsh[rmq_pkg::RW-1:0];
          quo <= {quo[rmq_pkg::NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== test/rmq_checker.sv =====
module rmq_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic         m_tuser,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] quat;
    logic        invalid;
  } quat_result_t;

  quat_result_t quat_expected[$];
  logic signed [15:0] prev_quat[4];
  logic prev_stored;

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic quat_result_t convert(input logic [143:0] mat, input logic align);
    longint a[9];
    longint c[4];
    longint v[4];
    longint q[4];
    longint one;
    longint lim;
    longint tr;
    longint dot;
    logic [63:0] sum;
    logic [63:0] norm;
    logic [63:0] m;
    logic [63:0] r;
    int k;
    quat_result_t res;
    one = longint'(1) << rmq_pkg::FRAC_BITS;
    lim = one < 32767 ? one : 32767;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(mat[16*i +: 16]));
    tr = a[0] + a[4] + a[8];
    c[0] = one + tr;
    c[1] = one + 2 * a[0] - tr;
    c[2] = one + 2 * a[4] - tr;
    c[3] = one + 2 * a[8] - tr;
    k = 0;
    for (int i = 1; i < 4; i++) if (c[i] > c[k]) k = i;
    res = '0;
    if (c[k] <= 0) begin
      res.invalid = 1'b1;
      return res;
    end
    case (k)
      0: begin
        v[0] = c[k]; v[1] = a[7] - a[5]; v[2] = a[2] - a[6]; v[3] = a[3] - a[1];
      end
      1: begin
        v[1] = c[k]; v[0] = a[7] - a[5]; v[2] = a[1] + a[3]; v[3] = a[2] + a[6];
      end
      2: begin
        v[2] = c[k]; v[0] = a[2] - a[6]; v[1] = a[1] + a[3]; v[3] = a[5] + a[7];
      end
      default: begin
        v[3] = c[k]; v[0] = a[3] - a[1]; v[1] = a[2] + a[6]; v[2] = a[5] + a[7];
      end
    endcase
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      sum = sum + m * m;
    end
    norm = isqrt(sum);
    for (int i = 0; i < 4; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      r = (m * one + norm / 2) / norm;
      q[i] = r > lim ? lim : longint'(r);
      if (v[i] < 0) q[i] = -q[i];
    end
    if (align && prev_stored) begin
      dot = 0;
      for (int i = 0; i < 4; i++) dot += q[i] * longint'(prev_quat[i]);
      if (dot < 0) for (int i = 0; i < 4; i++) q[i] = -q[i];
    end else if (q[0] < 0) begin
      for (int i = 0; i < 4; i++) q[i] = -q[i];
    end
    for (int i = 0; i < 4; i++) begin
      prev_quat[i] = 16'(q[i]);
      res.quat[16*i +: 16] = 16'(q[i]);
    end
    prev_stored = 1'b1;
    return res;
  endfunction

  assign pending = quat_expected.size();

  always @(posedge clk) begin
    quat_result_t want;
    if (rst) begin
      quat_expected.delete();
      for (int i = 0; i < 4; i++) prev_quat[i] = '0;
      prev_stored = 1'b0;
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) quat_expected.push_back(convert(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (quat_expected.size() == 0) begin
          if (fail_count < 10) $display("Unexpected item: %h %b", m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = quat_expected.pop_front();
          if (want.quat !== m_tdata || want.invalid !== m_tuser) begin
            if (fail_count < 10)
              $display("Mismatch: expected %h %b, got %h %b",
                       want.quat, want.invalid, m_tdata, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;
  int           fail_count;
  int           pending;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           hold_cycles = 0;
  logic         hold_req = 1'b0;
  logic         hold_taken = 1'b0;
  longint       cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rotation_matrix_to_quaternion_unit dut (.*);

  rmq_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 2000;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'(-16384);
      2: return 16'(16384);
      3: return 16'($urandom_range(4)) - 16'd2;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [143:0] rotation(input int axis, input int sgn);
    logic [143:0] d;
    int ang;
    real th;
    real cs;
    real sn;
    d = '0;
    ang = $urandom_range(359);
    th = ang * 3.14159265 / 180.0;
    cs = $cos(th) * 16384.0;
    sn = $sin(th) * 16384.0 * sgn;
    d[16*(axis*4) +: 16] = 16'd16384;
    d[16*(((axis+1)%3)*4) +: 16] = 16'($rtoi(cs));
    d[16*(((axis+2)%3)*4) +: 16] = 16'($rtoi(cs));
    d[16*(((axis+1)%3)*3 + (axis+2)%3) +: 16] = 16'(-$rtoi(sn));
    d[16*(((axis+2)%3)*3 + (axis+1)%3) +: 16] = 16'($rtoi(sn));
    return d;
  endfunction

  task automatic send_item(input logic [143:0] d, input logic align);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= align;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic [143:0] d;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        for (int i = 0; i < 9; i++) d[16*i +: 16] = rand_entry();
      end else begin
        d = rotation($urandom_range(2), $urandom_range(1) ? 1 : -1);
      end
      send_item(d, $urandom_range(1));
    end
  endtask

  initial begin
    logic [143:0] d;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    d = '0;
    d[0 +: 16] = 16'd16384; d[64 +: 16] = 16'd16384; d[128 +: 16] = 16'd16384;
    send_item(d, 1'b1);
    send_item(d, 1'b0);
    for (int axis = 0; axis < 3; axis++) begin
      d = '0;
      for (int i = 0; i < 3; i++) d[16*(i*4) +: 16] = (i == axis) ? 16'd16384 : 16'(-16384);
      send_item(d, 1'b1);
      send_item(d, 1'b0);
    end
    send_item('0, 1'b1);
    d = {9{16'(-16384)}};
    send_item(d, 1'b0);
    d = {9{16'h7fff}};
    send_item(d, 1'b1);
    d = {9{16'h8000}};
    send_item(d, 1'b1);
    d = {9{16'hffff}};
    send_item(d, 1'b0);
    d = {9{16'd16384}};
    send_item(d, 1'b1);
    send_item(rotation(0, 1), 1'b1);
    send_item(rotation(1, -1), 1'b1);
    send_item(rotation(2, 1), 1'b0);
    send_random(300);
    send_idle = 49;
    send_random(300);
    send_idle = 0;
    recv_stall = 49;
    hold_req <= 1'b1;
    send_random(300);
    send_idle = 26;
    recv_stall = 26;
    send_random(430);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/rmq_pkg.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_unit.sv
test/rmq_checker.sv
test/tb.sv
